@@ rtl/gld_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF LZW decoder package
// Shared types, constants and controller/datapath command structures.
// ----------------------------------------------------------------------------
package gld_pkg;

  localparam int MAX_CODE_BITS   = 12;
  localparam int BIT_BUFFER_BITS = 32;
  localparam int STORE_DEPTH     = 1 << MAX_CODE_BITS;
  localparam int ADDR_W          = MAX_CODE_BITS;
  localparam int CNT_W           = MAX_CODE_BITS + 1;
  localparam int HELD_W          = $clog2(BIT_BUFFER_BITS + 1);

  // Operation codes of an input item.
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // Status codes of a result item.
  localparam logic [2:0] ST_TAKEN   = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_PIXEL   = 3'd2;
  localparam logic [2:0] ST_NEED    = 3'd3;
  localparam logic [2:0] ST_END     = 3'd4;
  localparam logic [2:0] ST_BADSIZE = 3'd5;
  localparam logic [2:0] ST_LIMIT   = 3'd6;

  // Stream phases.
  localparam logic [1:0] PH_SIZE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic [2:0] status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CODE,
    S_WALK_RD,
    S_WALK,
    S_ROOT,
    S_POP_RD,
    S_POP,
    S_OUT
  } ctl_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic start_clear;   // clear decoding state
    logic push_byte;     // handle a stream byte
    logic take_code;     // extract a code and classify it
    logic walk_init;     // set up a chain walk for the current code
    logic walk_rd;       // issue a table read for the walk cursor
    logic walk_step;     // push suffix and follow prefix
    logic finish_root;   // push root, add entry, update history
    logic pop_rd;        // read the top of the stack
    logic pop_done;      // deliver the popped pixel
    logic set_result;    // load result register with status below
    logic [2:0] status;
  } ctl_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic       limit_hit;
    logic       stack_empty;
    logic       size_phase;
    logic       few_bits;
    logic       done_phase;
    logic       code_clear;
    logic       code_end;
    logic       first_pending;
    logic       walk_more;
    logic [2:0] push_status;
  } dp_stat_t;

endpackage

@@ rtl/gif_lzw_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF LZW decoder
// Decodes a GIF raster data section into palette indices, one per request.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | op, data_byte
//  out     | output    | out_valid / out_ready  | pixel, status
//  cfg     | input     | cfg_valid / cfg_ready  | pixel_limit
//
// One item is in flight at a time. A byte push or start passes through
// dispatch and the result state; a pixel from a filled stack passes through
// dispatch, stack read, pop and the result state. A stack refill re-enters the
// code state per clear code and visits walk read and walk per chain step.
// Synchronous reset clears all control state; tables need no clearing.
// A stalled result holds the block until out_ready.
// ----------------------------------------------------------------------------
module gif_lzw_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gld_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gld_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import gld_pkg::*;

  ctl_cmd_t   cmd;
  dp_stat_t   stat;
  logic       busy;
  logic       in_fire;
  logic       out_fire;
  logic [1:0] in_data_q_op;

  assign in_ready  = !busy;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  gld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .op       (in_data_q_op),
    .out_free (out_fire),
    .stat     (stat),
    .busy     (busy),
    .cmd      (cmd)
  );

  // Held op of the item being worked on.
  always_ff @(posedge clk) begin
    if (in_fire) in_data_q_op <= in_data.op;
  end

  gld_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .in_item      (in_data),
    .cfg_fire     (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .out_take     (out_fire),
    .stat         (stat),
    .result_valid (out_valid),
    .result       (out_data)
  );

`ifndef SYNTHESIS
  // No new item while a result is still pending.
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("item accepted while result pending");
  // Every accepted item leads to a busy block on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready) else $error("block not busy after item");
  // A result always carries one of the defined status codes.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_LIMIT) else $error("bad status code");
`endif

endmodule

@@ rtl/gld_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF LZW decoder controller
// Sequences one item at a time through byte push, code take, chain walk and pop.
// ----------------------------------------------------------------------------
module gld_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [1:0]        op,
  input  logic              out_free,
  input  gld_pkg::dp_stat_t stat,
  output logic              busy,
  output gld_pkg::ctl_cmd_t cmd
);
  import gld_pkg::*;

  ctl_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (op == OP_PIXEL && !stat.limit_hit) begin
          state_next = stat.stack_empty ? S_CODE : S_POP_RD;
        end else begin
          state_next = S_OUT;
        end
      end
      S_CODE: begin
        if (stat.size_phase || stat.few_bits || stat.code_end) state_next = S_OUT;
        else if (stat.code_clear) state_next = S_CODE;
        else if (stat.first_pending) state_next = S_POP_RD;
        else state_next = S_WALK_RD;
      end
      S_WALK_RD: begin
        state_next = stat.walk_more ? S_WALK : S_ROOT;
      end
      S_WALK:   state_next = S_WALK_RD;
      S_ROOT:   state_next = S_POP_RD;
      S_POP_RD: state_next = S_POP;
      S_POP:    state_next = S_OUT;
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    case (state)
      S_DISPATCH: begin
        if (op == OP_PUSH) begin
          cmd.push_byte  = 1'b1;
          cmd.set_result = 1'b1;
          cmd.status     = stat.push_status;
        end else if (op == OP_PIXEL) begin
          if (stat.limit_hit) begin
            cmd.set_result = 1'b1;
            cmd.status     = ST_LIMIT;
          end
        end else begin
          if (op == OP_START) cmd.start_clear = 1'b1;
          cmd.set_result = 1'b1;
          cmd.status     = ST_TAKEN;
        end
      end
      S_CODE: begin
        if (stat.size_phase) begin
          cmd.set_result = 1'b1;
          cmd.status     = ST_NEED;
        end else if (stat.few_bits) begin
          cmd.set_result = 1'b1;
          cmd.status     = stat.done_phase ? ST_END : ST_NEED;
        end else begin
          cmd.take_code = 1'b1;
          if (stat.code_end) begin
            cmd.set_result = 1'b1;
            cmd.status     = ST_END;
          end else if (!stat.code_clear && !stat.first_pending) begin
            cmd.walk_init = 1'b1;
          end
        end
      end
      S_WALK_RD: cmd.walk_rd     = stat.walk_more;
      S_WALK:    cmd.walk_step   = 1'b1;
      S_ROOT:    cmd.finish_root = 1'b1;
      S_POP_RD:  cmd.pop_rd      = 1'b1;
      S_POP: begin
        cmd.pop_done   = 1'b1;
        cmd.set_result = 1'b1;
        cmd.status     = ST_PIXEL;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/gld_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF LZW decoder datapath
// Bit buffer, code tables, pixel stack and counters, driven by commands.
// ----------------------------------------------------------------------------
module gld_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  gld_pkg::in_item_t in_item,
  input  logic              cfg_fire,
  input  logic [31:0]       cfg_data,
  input  gld_pkg::ctl_cmd_t cmd,
  input  logic              out_take,
  output gld_pkg::dp_stat_t stat,
  output logic              result_valid,
  output gld_pkg::out_item_t result
);
  import gld_pkg::*;

  // Memories.
  logic [ADDR_W-1:0] prefix_mem [STORE_DEPTH];
  logic [7:0]        suffix_mem [STORE_DEPTH];
  logic [7:0]        stack_mem  [STORE_DEPTH];

  logic [31:0]                pixel_limit;
  logic [BIT_BUFFER_BITS-1:0] bit_buffer;
  logic [HELD_W-1:0]          bits_held;
  logic [7:0]                 block_bytes_left;
  logic [1:0]                 stream_phase;
  logic [3:0]                 root_bits;
  logic [3:0]                 code_width;
  logic [CNT_W-1:0]           next_free;
  logic [ADDR_W-1:0]          previous_code;
  logic [7:0]                 first_symbol;
  logic [CNT_W-1:0]           stack_count;
  logic [31:0]                pixels_out;
  logic                       first_pending;
  in_item_t                   item;

  // Walk registers.
  logic [CNT_W-1:0]  cur;
  logic [CNT_W-1:0]  depth;
  logic [ADDR_W-1:0] cur_code;
  logic [ADDR_W-1:0] rd_prefix;
  logic [7:0]        rd_suffix;
  logic [7:0]        rd_stack;

  // Code extraction.
  logic [ADDR_W-1:0] code_mask;
  logic [ADDR_W-1:0] code_word;
  logic [CNT_W-1:0]  clr_code;
  logic [CNT_W-1:0]  lowest;
  logic [7:0]        root_sym;

  assign code_mask = ADDR_W'((1 << code_width) - 1);
  assign code_word = bit_buffer[ADDR_W-1:0] & code_mask;
  assign clr_code  = CNT_W'(1) << root_bits;
  assign lowest    = clr_code + CNT_W'(2);
  assign root_sym  = cur[7:0];

  always_comb begin
    stat.limit_hit     = (pixels_out >= pixel_limit);
    stat.stack_empty   = (stack_count == '0);
    stat.size_phase    = (stream_phase == PH_SIZE);
    stat.few_bits      = (bits_held < HELD_W'(code_width));
    stat.done_phase    = (stream_phase == PH_DONE);
    stat.code_clear    = ({1'b0, code_word} == clr_code);
    stat.code_end      = ({1'b0, code_word} == clr_code + CNT_W'(1));
    stat.first_pending = first_pending;
    stat.walk_more     = (cur >= lowest) && (cur < next_free)
                         && (depth < CNT_W'(STORE_DEPTH - 1));
    case (stream_phase)
      PH_SIZE: stat.push_status =
        (item.data_byte < 8'd2 || item.data_byte > 8'd9
         || 32'(item.data_byte) + 32'd1 > 32'(MAX_CODE_BITS)) ? ST_BADSIZE : ST_TAKEN;
      PH_DATA: stat.push_status =
        (32'(bits_held) + 32'd8 > 32'(BIT_BUFFER_BITS)) ? ST_FULL : ST_TAKEN;
      PH_LEN:  stat.push_status = ST_TAKEN;
      default: stat.push_status = ST_END;
    endcase
  end

  // Input item capture and configuration register.
  always_ff @(posedge clk) begin
    if (in_fire) item <= in_item;
    if (rst) begin
      pixel_limit <= '1;
    end else if (cfg_fire) begin
      pixel_limit <= cfg_data;
    end
  end

  // Table and stack reads.
  always_ff @(posedge clk) begin
    if (cmd.walk_rd) begin
      rd_prefix <= prefix_mem[cur[ADDR_W-1:0]];
      rd_suffix <= suffix_mem[cur[ADDR_W-1:0]];
    end
    if (cmd.pop_rd) begin
      rd_stack <= stack_mem[ADDR_W'(stack_count - CNT_W'(1))];
    end
  end

  // Stack writes.
  always_ff @(posedge clk) begin
    if (cmd.take_code && first_pending && !stat.code_clear && !stat.code_end) begin
      stack_mem[0] <= code_word[7:0];
    end else if (cmd.walk_init && {1'b0, code_word} >= next_free) begin
      stack_mem[0] <= first_symbol;
    end else if (cmd.walk_step) begin
      stack_mem[depth[ADDR_W-1:0]] <= rd_suffix;
    end else if (cmd.finish_root) begin
      stack_mem[depth[ADDR_W-1:0]] <= root_sym;
    end
  end

  // Table writes.
  always_ff @(posedge clk) begin
    if (cmd.finish_root && !next_free[CNT_W-1]) begin
      prefix_mem[next_free[ADDR_W-1:0]] <= previous_code;
      suffix_mem[next_free[ADDR_W-1:0]] <= root_sym;
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst || cmd.start_clear) begin
      bit_buffer       <= '0;
      bits_held        <= '0;
      block_bytes_left <= '0;
      stream_phase     <= PH_SIZE;
      root_bits        <= '0;
      code_width       <= '0;
      next_free        <= '0;
      previous_code    <= '0;
      first_symbol     <= '0;
      stack_count      <= '0;
      pixels_out       <= '0;
      first_pending    <= 1'b0;
      cur              <= '0;
      depth            <= '0;
      cur_code         <= '0;
    end else begin
      if (cmd.push_byte && stat.push_status == ST_TAKEN) begin
        case (stream_phase)
          PH_SIZE: begin
            root_bits     <= item.data_byte[3:0];
            code_width    <= item.data_byte[3:0] + 4'd1;
            next_free     <= (CNT_W'(1) << item.data_byte[3:0]) + CNT_W'(2);
            first_pending <= 1'b1;
            stream_phase  <= PH_LEN;
          end
          PH_LEN: begin
            if (item.data_byte == 8'd0) begin
              stream_phase <= PH_DONE;
            end else begin
              block_bytes_left <= item.data_byte;
              stream_phase     <= PH_DATA;
            end
          end
          PH_DATA: begin
            bit_buffer <= bit_buffer
              | (BIT_BUFFER_BITS'(item.data_byte) << bits_held);
            bits_held        <= bits_held + HELD_W'(8);
            block_bytes_left <= block_bytes_left - 8'd1;
            if (block_bytes_left == 8'd1) stream_phase <= PH_LEN;
          end
          default: ;
        endcase
      end
      if (cmd.take_code) begin
        // The end code drops whatever bits are still buffered.
        if (stat.code_end) begin
          bit_buffer   <= '0;
          bits_held    <= '0;
          stream_phase <= PH_DONE;
        end else begin
          bit_buffer <= bit_buffer >> code_width;
          bits_held  <= bits_held - HELD_W'(code_width);
        end
        if (stat.code_clear) begin
          next_free     <= lowest;
          code_width    <= root_bits + 4'd1;
          first_pending <= 1'b1;
        end else if (!stat.code_end && first_pending) begin
          first_pending <= 1'b0;
          previous_code <= code_word;
          first_symbol  <= code_word[7:0];
          stack_count   <= CNT_W'(1);
        end
      end
      if (cmd.walk_init) begin
        cur_code <= code_word;
        if ({1'b0, code_word} >= next_free) begin
          depth <= CNT_W'(1);
          cur   <= {1'b0, previous_code};
        end else begin
          depth <= '0;
          cur   <= {1'b0, code_word};
        end
      end
      if (cmd.walk_step) begin
        depth <= depth + CNT_W'(1);
        cur   <= {1'b0, rd_prefix};
      end
      if (cmd.finish_root) begin
        stack_count <= depth + CNT_W'(1);
        if (!next_free[CNT_W-1]) begin
          next_free <= next_free + CNT_W'(1);
          if ((next_free + CNT_W'(1)) >= (CNT_W'(1) << code_width)
              && code_width < 4'(MAX_CODE_BITS)) begin
            code_width <= code_width + 4'd1;
          end
        end
        previous_code <= cur_code;
        first_symbol  <= root_sym;
      end
      if (cmd.pop_done) begin
        stack_count <= stack_count - CNT_W'(1);
        pixels_out  <= pixels_out + 32'd1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.set_result) begin
      result_valid <= 1'b1;
    end else if (out_take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      result.status <= cmd.status;
      result.pixel  <= cmd.pop_done ? rd_stack : 8'd0;
    end
  end

endmodule
